/* src/rlpe_pkg.sv */
// Shared types, constants and the palette table for the GRB LED pulse encoder.
`timescale 1ns / 1ps
package rlpe_pkg;

    // Field widths
    localparam int CH_W    = 8;
    localparam int TICK_W  = 12;
    localparam int PULSE_W = 6;
    localparam int LEVEL_W = 3;
    localparam int PROD_W  = CH_W + LEVEL_W;
    localparam int OUT_W   = 2 + 2 * TICK_W;

    // Divide by five: floor(x * 3277 / 2^14) is exact for x < 16384
    localparam int RECIP5_W     = 12;
    localparam int RECIP5_SHIFT = 14;
    localparam logic [RECIP5_W-1:0] RECIP5 = 12'd3277;
    localparam int SCALE_MUL_W  = PROD_W + RECIP5_W;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;
    localparam logic [CH_W-1:0] CH_ORANGE_G = 8'd165;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LEN  = 3'd5;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_BRIGHTNESS = 3'd5;
    localparam logic [PULSE_W-1:0] RST_ZERO_HIGH  = 6'd3;
    localparam logic [PULSE_W-1:0] RST_ZERO_LOW   = 6'd6;
    localparam logic [PULSE_W-1:0] RST_ONE_HIGH   = 6'd6;
    localparam logic [PULSE_W-1:0] RST_ONE_LOW    = 6'd3;
    localparam logic [TICK_W-1:0]  RST_RESET_LEN  = 12'd800;

    // Palette letters (ASCII)
    localparam logic [7:0] PAL_OFF    = 8'h30; // '0'
    localparam logic [7:0] PAL_WHITE  = 8'h57; // 'W'
    localparam logic [7:0] PAL_RED    = 8'h52; // 'R'
    localparam logic [7:0] PAL_GREEN  = 8'h47; // 'G'
    localparam logic [7:0] PAL_BLUE   = 8'h42; // 'B'
    localparam logic [7:0] PAL_YELLOW = 8'h59; // 'Y'
    localparam logic [7:0] PAL_CYAN   = 8'h43; // 'C'
    localparam logic [7:0] PAL_PURPLE = 8'h50; // 'P'
    localparam logic [7:0] PAL_ORANGE = 8'h4F; // 'O'

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DATA,
        S_RST
    } t_state;

    typedef struct packed {
        logic            ok;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    // Palette letter to RGB; ok is low for an unknown letter
    function automatic t_rgb palette_lookup(input logic [7:0] code);
        t_rgb c;
        c = '{ok: 1'b1, r: '0, g: '0, b: '0};
        unique case (code)
            PAL_OFF:    ;
            PAL_WHITE:  begin c.r = CH_MAX; c.g = CH_MAX; c.b = CH_MAX; end
            PAL_RED:    c.r = CH_MAX;
            PAL_GREEN:  c.g = CH_MAX;
            PAL_BLUE:   c.b = CH_MAX;
            PAL_YELLOW: begin c.r = CH_MAX; c.g = CH_MAX; end
            PAL_CYAN:   begin c.g = CH_MAX; c.b = CH_MAX; end
            PAL_PURPLE: begin c.r = CH_MAX; c.b = CH_MAX; end
            PAL_ORANGE: begin c.r = CH_MAX; c.g = CH_ORANGE_G; end
            default:    c.ok = 1'b0;
        endcase
        return c;
    endfunction

endpackage

/* src/rlpe_scale.sv */
// Shared brightness scaler: channel * level, registered, then divide by five.
`timescale 1ns / 1ps
module rlpe_scale (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [rlpe_pkg::CH_W-1:0]          i_chan,
    input  logic [rlpe_pkg::LEVEL_W-1:0]       i_level,
    output logic [rlpe_pkg::CH_W-1:0]          o_scaled
);

    localparam int QUOT_W = rlpe_pkg::SCALE_MUL_W - rlpe_pkg::RECIP5_SHIFT;

    logic [rlpe_pkg::PROD_W-1:0]      r_prod;
    logic [rlpe_pkg::SCALE_MUL_W-1:0] w_mul;
    logic [QUOT_W-1:0]                w_quot;

    // Stage one: channel times brightness level
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= rlpe_pkg::PROD_W'(i_chan) * rlpe_pkg::PROD_W'(i_level);
        end
    end

    // Stage two: reciprocal multiply for the divide by five, then saturate
    assign w_mul  = rlpe_pkg::SCALE_MUL_W'(r_prod)
                  * rlpe_pkg::SCALE_MUL_W'(rlpe_pkg::RECIP5);
    assign w_quot = w_mul[rlpe_pkg::SCALE_MUL_W-1:rlpe_pkg::RECIP5_SHIFT];
    assign o_scaled = (w_quot > QUOT_W'(rlpe_pkg::CH_MAX)) ? rlpe_pkg::CH_MAX
                    : w_quot[rlpe_pkg::CH_W-1:0];

endmodule

/* src/rgb_led_pulse_encoder.sv */
// Top level of the one-wire GRB LED pulse encoder.
//
//  channel | dir | transfer when           | payload
//  s_axis  | in  | s_axis_tvalid & tready  | one LED: color, kind, end of frame
//  m_axis  | out | m_axis_tvalid & tready  | one pulse item: levels and ticks
//  cfg     | in  | i_cfg_we                | register index and value
//
// An LED is accepted, then passes through the shared scaler one channel at a time
// (multiply by level, then divide by five), then one pulse item per cycle while
// m_axis is not stalled: 24 data items plus one reset item at frame end.
// An unknown palette letter skips the scaler and the data items.
// Reset (synchronous, active low) returns the configuration registers to their
// defaults and the sequencer to idle. A stalled m_axis holds the output register and,
// in the data and reset states, the sequencer; s_axis_tready is high only in idle.
`timescale 1ns / 1ps
module rgb_led_pulse_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: palette_code[7:0], red_value[15:8], green_value[23:16], blue_value[31:24]
    input  logic [31:0] s_axis_tdata,
    // tuser: kind[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: first_level[0], first_ticks[12:1], second_level[13],
    //        second_ticks[25:14], zero fill[31:26]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [rlpe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rlpe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int BITS = 3 * rlpe_pkg::CH_W;
    localparam logic [4:0] LAST_BIT = 5'(BITS - 1);
    localparam logic [1:0] LAST_CH  = 2'd2;

    // Configuration registers
    logic [rlpe_pkg::LEVEL_W-1:0] r_level;
    logic [rlpe_pkg::PULSE_W-1:0] r_zero_high, r_zero_low, r_one_high, r_one_low;
    logic [rlpe_pkg::TICK_W-1:0]  r_reset_len;

    // Sequencer and item state
    rlpe_pkg::t_state r_state, n_state;
    logic [1:0]            r_ch, n_ch;
    logic [4:0]            r_bit, n_bit;
    logic [BITS-1:0]       r_word, n_word;
    logic [rlpe_pkg::CH_W-1:0] r_r, r_g, r_b, n_r, n_g, n_b;
    logic                  r_eof, n_eof;

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic [rlpe_pkg::OUT_W-1:0] r_out_data, n_out_data;
    logic                      r_out_last, n_out_last;

    logic                      w_accept;
    logic                      w_load_out;
    logic                      w_scale_en;
    logic [rlpe_pkg::CH_W-1:0] w_chan;
    logic [rlpe_pkg::CH_W-1:0] w_scaled;
    rlpe_pkg::t_rgb            w_pal;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_load_out = !r_out_valid || m_axis_tready;
    assign w_pal      = rlpe_pkg::palette_lookup(s_axis_tdata[7:0]);

    // Channel feed to the scaler in G, R, B order
    always_comb begin
        unique case (r_ch)
            2'd0:    w_chan = r_g;
            2'd1:    w_chan = r_r;
            default: w_chan = r_b;
        endcase
    end

    rlpe_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (w_scale_en),
        .i_chan   (w_chan),
        .i_level  (r_level),
        .o_scaled (w_scaled)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= rlpe_pkg::RST_BRIGHTNESS;
            r_zero_high <= rlpe_pkg::RST_ZERO_HIGH;
            r_zero_low  <= rlpe_pkg::RST_ZERO_LOW;
            r_one_high  <= rlpe_pkg::RST_ONE_HIGH;
            r_one_low   <= rlpe_pkg::RST_ONE_LOW;
            r_reset_len <= rlpe_pkg::RST_RESET_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rlpe_pkg::CFG_BRIGHTNESS: r_level <= i_cfg_data[rlpe_pkg::LEVEL_W-1:0];
                rlpe_pkg::CFG_ZERO_HIGH:  r_zero_high <= i_cfg_data[rlpe_pkg::PULSE_W-1:0];
                rlpe_pkg::CFG_ZERO_LOW:   r_zero_low <= i_cfg_data[rlpe_pkg::PULSE_W-1:0];
                rlpe_pkg::CFG_ONE_HIGH:   r_one_high <= i_cfg_data[rlpe_pkg::PULSE_W-1:0];
                rlpe_pkg::CFG_ONE_LOW:    r_one_low <= i_cfg_data[rlpe_pkg::PULSE_W-1:0];
                rlpe_pkg::CFG_RESET_LEN:  r_reset_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state, item registers and pulse item generation
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_bit       = r_bit;
        n_word      = r_word;
        n_r         = r_r;
        n_g         = r_g;
        n_b         = r_b;
        n_eof       = r_eof;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_scale_en  = 1'b0;
        s_axis_tready = (r_state == rlpe_pkg::S_IDLE);

        unique case (r_state)
            rlpe_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_eof = s_axis_tlast;
                    n_ch  = '0;
                    n_bit = '0;
                    if (s_axis_tuser) begin
                        n_r = s_axis_tdata[15:8];
                        n_g = s_axis_tdata[23:16];
                        n_b = s_axis_tdata[31:24];
                        n_state = rlpe_pkg::S_MUL;
                    end else begin
                        n_r = w_pal.r;
                        n_g = w_pal.g;
                        n_b = w_pal.b;
                        if (w_pal.ok) begin
                            n_state = rlpe_pkg::S_MUL;
                        end else if (s_axis_tlast) begin
                            n_state = rlpe_pkg::S_RST;
                        end
                    end
                end
            end
            rlpe_pkg::S_MUL: begin
                w_scale_en = 1'b1;
                n_state    = rlpe_pkg::S_DIV;
            end
            rlpe_pkg::S_DIV: begin
                n_word = {r_word[BITS-rlpe_pkg::CH_W-1:0], w_scaled};
                if (r_ch == LAST_CH) begin
                    n_ch    = '0;
                    n_state = rlpe_pkg::S_DATA;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = rlpe_pkg::S_MUL;
                end
            end
            rlpe_pkg::S_DATA: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    // second_ticks, second_level, first_ticks, first_level
                    if (r_word[BITS-1]) begin
                        n_out_data = {rlpe_pkg::TICK_W'(r_one_low), 1'b0,
                                      rlpe_pkg::TICK_W'(r_one_high), 1'b1};
                    end else begin
                        n_out_data = {rlpe_pkg::TICK_W'(r_zero_low), 1'b0,
                                      rlpe_pkg::TICK_W'(r_zero_high), 1'b1};
                    end
                    n_out_last = (r_bit == LAST_BIT) && !r_eof;
                    n_word     = {r_word[BITS-2:0], 1'b0};
                    if (r_bit == LAST_BIT) begin
                        n_bit   = '0;
                        n_state = r_eof ? rlpe_pkg::S_RST : rlpe_pkg::S_IDLE;
                    end else begin
                        n_bit = r_bit + 5'd1;
                    end
                end
            end
            rlpe_pkg::S_RST: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {rlpe_pkg::TICK_W'(0), 1'b0, r_reset_len, 1'b0};
                    n_out_last  = 1'b1;
                    n_state     = rlpe_pkg::S_IDLE;
                end
            end
            default: n_state = rlpe_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlpe_pkg::S_IDLE;
            r_ch        <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_r        <= n_r;
        r_g        <= n_g;
        r_b        <= n_b;
        r_eof      <= n_eof;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(32 - rlpe_pkg::OUT_W)'(0), r_out_data};
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlpe_pkg::S_DATA) |-> (r_bit <= LAST_BIT))
        else $error("bit counter ran past the last data bit");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlpe_pkg::S_MUL || r_state == rlpe_pkg::S_DIV) |-> (r_ch != 2'd3))
        else $error("scaler channel index out of range");

    a_reset_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast)
        else $error("reset item not marked as last");

    a_direct_scales: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser) |=> (r_state == rlpe_pkg::S_MUL))
        else $error("direct color did not start the scaler");

endmodule
